// ----- hdl/tewg_pkg.sv -----
`default_nettype none

package tewg_pkg;

    localparam int FRAME_BITS    = 24;
    localparam int VALUE_BITS    = 16;
    localparam int SINE_DEPTH    = 256;

    localparam int SINE_AW       = $clog2(SINE_DEPTH);
    localparam int TAB_BITS      = 16;
    localparam int TAB_FRAC      = 15;
    localparam int MUL_BITS      = (VALUE_BITS > SINE_AW + 1) ? VALUE_BITS : SINE_AW + 1;
    localparam int MC_BITS       = (FRAME_BITS > TAB_BITS - 1) ? FRAME_BITS : TAB_BITS - 1;
    localparam int ACC_BITS      = MUL_BITS + MC_BITS + 1;
    localparam int CNT_BITS      = $clog2(MUL_BITS);
    localparam int CFG_DATA_BITS = (FRAME_BITS > VALUE_BITS) ? FRAME_BITS : VALUE_BITS;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ENABLE = 3'd0,
        REG_SHAPE  = 3'd1,
        REG_START  = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_AMP    = 3'd4,
        REG_BASE   = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        SHAPE_STEP    = 3'd0,
        SHAPE_PULSE   = 3'd1,
        SHAPE_DOUBLET = 3'd2,
        SHAPE_RAMP    = 3'd3,
        SHAPE_SINE    = 3'd4
    } t_shape;

    typedef struct packed {
        logic                          enable;
        t_shape                        shape;
        logic [FRAME_BITS-1:0]         start_frame;
        logic [FRAME_BITS-1:0]         width_frames;
        logic signed [VALUE_BITS-1:0]  amplitude;
        logic signed [VALUE_BITS-1:0]  base_value;
    } t_cfg;

    typedef struct packed {
        logic                   start;
        logic                   div;
        logic [MUL_BITS-1:0]    mag;
        logic [MC_BITS-1:0]     mcand;
        logic [MC_BITS-1:0]     addend;
        logic [FRAME_BITS-1:0]  den;
    } t_md_req;

    typedef struct packed {
        logic                 done;
        logic [MUL_BITS-1:0]  result;
    } t_md_rsp;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_ADD,
        MD_DIV
    } t_md_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_CMP,
        ST_SEL,
        ST_PHASE,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef logic [SINE_DEPTH-1:0][TAB_BITS-1:0] t_sine_tab;

    // sine of an angle in [0, pi/2], q30 in and out
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        return sum;
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] a;
        logic [63:0] v;
        logic        neg;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            a   = (64'(k) * TWO_PI_Q30) / SINE_DEPTH;
            neg = 1'b0;
            if (a >= PI_Q30) begin
                a   = a - PI_Q30;
                neg = 1'b1;
            end
            if (a > HALF_PI_Q30) begin
                a = PI_Q30 - a;
            end
            v = (sin_q30(a) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[k] = neg ? TAB_BITS'(-v) : TAB_BITS'(v);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ----- hdl/test_excitation_waveform_generator.sv -----
`default_nettype none

// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_restart
// output    out        o_valid / i_stall  o_value, o_frame_number
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// one transaction at a time; o_stall is high from acceptance until the result
// is loaded into the output register
// step, pulse, doublet and pass-through: bound, compare, select, output
// ramp: scaled by the shift-add and restoring divide unit, one bit per
// cycle, between select and output
// sine: phase divide then table scaling through the same unit, between
// select and output
// synchronous active-low reset clears config, frame count and output valid

module test_excitation_waveform_generator (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_restart,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [tewg_pkg::VALUE_BITS-1:0]  o_value,
    output logic [tewg_pkg::FRAME_BITS-1:0]         o_frame_number,
    input  logic                                    i_cfg_we,
    input  logic [tewg_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [tewg_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import tewg_pkg::*;

    localparam int F = FRAME_BITS;
    localparam int V = VALUE_BITS;

    t_cfg     s_cfg;
    t_md_req  s_req;
    t_md_rsp  s_rsp;

    t_state                 r_state;
    t_state                 n_state;
    logic [F-1:0]           r_frame;
    logic [F-1:0]           n_frame;
    logic [F:0]             r_end;
    logic [F:0]             n_end;
    logic [F:0]             r_mid;
    logic [F:0]             n_mid;
    logic                   r_ge_s;
    logic                   n_ge_s;
    logic                   r_le_e;
    logic                   n_le_e;
    logic                   r_le_m;
    logic                   n_le_m;
    logic                   r_neg;
    logic                   n_neg;
    logic signed [V:0]      r_x;
    logic signed [V:0]      n_x;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic signed [V-1:0]    r_value;
    logic signed [V-1:0]    n_value;
    logic [F-1:0]           r_fnum;
    logic [F-1:0]           n_fnum;

    logic                   s_accept;
    logic [F-1:0]           s_half_lo;
    logic [F-1:0]           s_half_hi;
    logic [F-1:0]           s_rise_num;
    logic [F:0]             s_fall_wide;
    logic [F-1:0]           s_fall_num;
    logic                   s_base_neg;
    logic [V-1:0]           s_base_mag;
    logic signed [V:0]      s_base_ext;
    logic signed [V:0]      s_amp_ext;
    logic [SINE_AW-1:0]     s_phase;
    logic [TAB_BITS-1:0]    s_tval;
    logic                   s_t_neg;
    logic [TAB_BITS-1:0]    s_t_abs;
    logic [V:0]             s_q_ext;
    logic signed [V-1:0]    s_sat;

    tewg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (s_cfg)
    );

    tewg_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .o_rsp   (s_rsp)
    );

    assign s_accept    = i_valid && !o_stall;
    assign s_half_lo   = {1'b0, s_cfg.width_frames[F-1:1]};
    assign s_half_hi   = s_cfg.width_frames - s_half_lo;
    assign s_rise_num  = r_frame - s_cfg.start_frame;
    assign s_fall_wide = r_end - {1'b0, r_frame};
    assign s_fall_num  = s_fall_wide[F-1:0];
    assign s_base_neg  = s_cfg.base_value[V-1];
    assign s_base_mag  = (s_cfg.base_value ^ {V{s_base_neg}}) + V'(s_base_neg);
    assign s_base_ext  = {s_cfg.base_value[V-1], s_cfg.base_value};
    assign s_amp_ext   = {s_cfg.amplitude[V-1], s_cfg.amplitude};
    assign s_phase     = s_rsp.result[SINE_AW-1:0];
    assign s_tval      = SINE_TAB[s_phase];
    assign s_t_neg     = s_tval[TAB_BITS-1];
    assign s_t_abs     = (s_tval ^ {TAB_BITS{s_t_neg}}) + TAB_BITS'(s_t_neg);
    assign s_q_ext     = {1'b0, s_rsp.result[V-1:0]};
    assign s_sat       = (r_x[V] != r_x[V-1])
                         ? (r_x[V] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}})
                         : r_x[V-1:0];

    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_end       = r_end;
        n_mid       = r_mid;
        n_ge_s      = r_ge_s;
        n_le_e      = r_le_e;
        n_le_m      = r_le_m;
        n_neg       = r_neg;
        n_x         = r_x;
        n_value     = r_value;
        n_fnum      = r_fnum;
        n_out_valid = r_out_valid && i_stall;
        s_req       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_restart) begin
                        n_frame = F'(1);
                    end else if (r_frame != {F{1'b1}}) begin
                        n_frame = r_frame + 1'b1;
                    end
                    n_state = ST_BOUND;
                end
            end
            ST_BOUND: begin
                n_end   = {1'b0, s_cfg.start_frame} + {1'b0, s_cfg.width_frames};
                n_mid   = {1'b0, s_cfg.start_frame} + {1'b0, s_half_lo};
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_ge_s  = (r_frame >= s_cfg.start_frame);
                n_le_e  = ({1'b0, r_frame} <= r_end);
                n_le_m  = ({1'b0, r_frame} <= r_mid);
                n_state = ST_SEL;
            end
            ST_SEL: begin
                n_x     = s_base_ext;
                n_neg   = s_base_neg;
                n_state = ST_OUT;
                if (s_cfg.enable) begin
                    case (s_cfg.shape)
                        SHAPE_STEP: begin
                            if (r_ge_s) begin
                                n_x = s_base_ext + s_amp_ext;
                            end
                        end
                        SHAPE_PULSE: begin
                            if (r_ge_s && r_le_e) begin
                                n_x = s_base_ext + s_amp_ext;
                            end
                        end
                        SHAPE_DOUBLET: begin
                            if (r_ge_s && r_le_m) begin
                                n_x = s_base_ext + s_amp_ext;
                            end else if (!r_le_m && r_le_e) begin
                                n_x = s_base_ext - s_amp_ext;
                            end
                        end
                        SHAPE_RAMP: begin
                            if (r_ge_s && r_le_m) begin
                                if (s_half_lo != '0) begin
                                    s_req.start  = 1'b1;
                                    s_req.div    = 1'b1;
                                    s_req.mag    = MUL_BITS'(s_base_mag);
                                    s_req.mcand  = MC_BITS'(s_rise_num);
                                    s_req.addend = MC_BITS'(s_half_lo >> 1);
                                    s_req.den    = s_half_lo;
                                    n_state      = ST_SCALE;
                                end
                            end else if (!r_le_m && r_le_e) begin
                                s_req.start  = 1'b1;
                                s_req.div    = 1'b1;
                                s_req.mag    = MUL_BITS'(s_base_mag);
                                s_req.mcand  = MC_BITS'(s_fall_num);
                                s_req.addend = MC_BITS'(s_half_hi >> 1);
                                s_req.den    = s_half_hi;
                                n_state      = ST_SCALE;
                            end
                        end
                        SHAPE_SINE: begin
                            if (r_ge_s && r_le_e) begin
                                if (s_cfg.width_frames == '0) begin
                                    n_x = '0;
                                end else begin
                                    s_req.start  = 1'b1;
                                    s_req.div    = 1'b1;
                                    s_req.mag    = MUL_BITS'(SINE_DEPTH);
                                    s_req.mcand  = MC_BITS'(s_rise_num);
                                    s_req.addend = '0;
                                    s_req.den    = s_cfg.width_frames;
                                    n_state      = ST_PHASE;
                                end
                            end
                        end
                        default: n_x = s_base_ext;
                    endcase
                end
            end
            ST_PHASE: begin
                if (s_rsp.done) begin
                    s_req.start  = 1'b1;
                    s_req.div    = 1'b0;
                    s_req.mag    = MUL_BITS'(s_base_mag);
                    s_req.mcand  = MC_BITS'(s_t_abs[TAB_BITS-2:0]);
                    s_req.addend = MC_BITS'(1) << (TAB_FRAC - 1);
                    s_req.den    = '0;
                    n_neg        = s_base_neg ^ s_t_neg;
                    n_state      = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (s_rsp.done) begin
                    n_x     = r_neg ? -$signed(s_q_ext) : $signed(s_q_ext);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_value     = s_sat;
                    n_fnum      = r_frame;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end   <= n_end;
        r_mid   <= n_mid;
        r_ge_s  <= n_ge_s;
        r_le_e  <= n_le_e;
        r_le_m  <= n_le_m;
        r_neg   <= n_neg;
        r_x     <= n_x;
        r_value <= n_value;
        r_fnum  <= n_fnum;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_value        = r_value;
    assign o_frame_number = r_fnum;

endmodule

`default_nettype wire

// ----- hdl/tewg_cfg.sv -----
`default_nettype none

module tewg_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [tewg_pkg::CFG_IDX_BITS-1:0]   i_idx,
    input  logic [tewg_pkg::CFG_DATA_BITS-1:0]  i_data,
    output tewg_pkg::t_cfg                      o_cfg
);
    import tewg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                REG_ENABLE: n_cfg.enable       = i_data[0];
                REG_SHAPE:  n_cfg.shape        = t_shape'(i_data[2:0]);
                REG_START:  n_cfg.start_frame  = i_data[FRAME_BITS-1:0];
                REG_WIDTH:  n_cfg.width_frames = i_data[FRAME_BITS-1:0];
                REG_AMP:    n_cfg.amplitude    = i_data[VALUE_BITS-1:0];
                REG_BASE:   n_cfg.base_value   = i_data[VALUE_BITS-1:0];
                default:    n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/tewg_muldiv.sv -----
`default_nettype none

module tewg_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tewg_pkg::t_md_req   i_req,
    output tewg_pkg::t_md_rsp   o_rsp
);
    import tewg_pkg::*;

    t_md_state              r_state;
    t_md_state              n_state;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [CNT_BITS-1:0]    n_cnt;
    logic                   r_done;
    logic                   n_done;
    logic                   r_div;
    logic                   n_div;
    logic [MUL_BITS-1:0]    r_mag;
    logic [MUL_BITS-1:0]    n_mag;
    logic [MC_BITS-1:0]     r_mcand;
    logic [MC_BITS-1:0]     n_mcand;
    logic [MC_BITS-1:0]     r_addend;
    logic [MC_BITS-1:0]     n_addend;
    logic [FRAME_BITS-1:0]  r_den;
    logic [FRAME_BITS-1:0]  n_den;
    logic [ACC_BITS-1:0]    r_acc;
    logic [ACC_BITS-1:0]    n_acc;

    logic [MC_BITS:0]       s_part;
    logic [MC_BITS:0]       s_diff;
    logic                   s_ge;

    // restoring step: partial remainder with the next dividend bit
    assign s_part = r_acc[ACC_BITS-2:MUL_BITS-1];
    assign s_ge   = (s_part >= (MC_BITS + 1)'(r_den));
    assign s_diff = s_part - (MC_BITS + 1)'(r_den);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_div    = r_div;
        n_mag    = r_mag;
        n_mcand  = r_mcand;
        n_addend = r_addend;
        n_den    = r_den;
        n_acc    = r_acc;
        unique case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_div    = i_req.div;
                    n_mag    = i_req.mag;
                    n_mcand  = i_req.mcand;
                    n_addend = i_req.addend;
                    n_den    = i_req.den;
                    n_acc    = '0;
                    n_cnt    = CNT_BITS'(MUL_BITS - 1);
                    n_state  = MD_MUL;
                end
            end
            MD_MUL: begin
                n_acc = (r_acc << 1) + (r_mag[MUL_BITS-1] ? ACC_BITS'(r_mcand) : '0);
                n_mag = r_mag << 1;
                if (r_cnt == '0) begin
                    n_state = MD_ADD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            MD_ADD: begin
                n_acc = r_acc + ACC_BITS'(r_addend);
                if (r_div) begin
                    n_cnt   = CNT_BITS'(MUL_BITS - 1);
                    n_state = MD_DIV;
                end else begin
                    n_done  = 1'b1;
                    n_state = MD_IDLE;
                end
            end
            MD_DIV: begin
                n_acc = {(s_ge ? s_diff : s_part), r_acc[MUL_BITS-2:0], s_ge};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = MD_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: n_state = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_div    <= n_div;
        r_mag    <= n_mag;
        r_mcand  <= n_mcand;
        r_addend <= n_addend;
        r_den    <= n_den;
        r_acc    <= n_acc;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_div ? r_acc[MUL_BITS-1:0]
                                : MUL_BITS'(r_acc[TAB_FRAC +: VALUE_BITS]);

endmodule

`default_nettype wire

// ----- hdl/tewg_checker.sv -----
`default_nettype none

module tewg_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic                                    o_stall,
    input  logic                                    o_valid,
    input  logic                                    i_stall,
    input  logic signed [tewg_pkg::VALUE_BITS-1:0]  o_value,
    input  logic [tewg_pkg::FRAME_BITS-1:0]         o_frame_number
);
    import tewg_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_frame_number))
        else $error("stalled output transaction changed");

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepted transaction");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // frame numbering starts at one
    a_frame_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_frame_number != '0)
        else $error("output frame number is zero");

endmodule

bind test_excitation_waveform_generator tewg_checker u_tewg_checker (.*);

`default_nettype wire
